/* rtl/smask_pkg.sv */
// ---------------------------------------------------------------------------
// smask_pkg
// Shared types and constants for the stream pattern mask block.
// ---------------------------------------------------------------------------
`default_nettype none

package smask_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 5;

  localparam logic [7:0] STAR_BYTE = 8'h2A;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0]      pattern_length;
    logic [CFG_DATA_W-1:0] pattern_high;
    logic [CFG_DATA_W-1:0] pattern_low;
  } cfg_t;

  // One output command: a single copied byte or a run of asterisks.
  typedef struct packed {
    logic             star;
    logic [LEN_W-1:0] run_len;
    logic [7:0]       data;
    logic             run_last;
    logic             stream_done;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/smask_stream_if.sv */
// ---------------------------------------------------------------------------
// smask stream interfaces
// Valid/ready channels for the input text stream and the masked output.
// ---------------------------------------------------------------------------
`default_nettype none

interface smask_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface smask_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  output ready);
endinterface

`default_nettype wire

/* rtl/smask_front.sv */
// ---------------------------------------------------------------------------
// smask_front
// Accepts bytes, keeps the pending window and, unless the command queue is
// full, decides once per cycle; full-window and end decisions push commands.
// ---------------------------------------------------------------------------
`default_nettype none

module smask_front
  import smask_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  logic         clk,
  input  logic         rst,
  smask_in_if.sink     byte_stream,
  input  cfg_t         cfg,
  input  logic         cmd_full,
  output logic         cmd_push,
  output cmd_t         cmd
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int WW = MAX_PATTERN * 8;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  logic [WW-1:0] win;
  logic [CW-1:0] cnt;
  logic          active;
  logic          flush;

  logic [LEN_W-1:0]    len;
  logic [2*CFG_DATA_W-1:0] pat;
  logic [WW-1:0]       win_app;
  logic [WW-1:0]       src_w;
  logic [LEN_W-1:0]    src_c;
  logic                src_last;
  logic [MAX_PATTERN-1:0] byte_ok;
  logic                full_window;
  logic                hit;
  logic                act;
  logic [LEN_W-1:0]    drop;
  logic [LEN_W-1:0]    cnt_next;
  logic                more;
  logic                take;
  logic                step;
  logic [WW-1:0]       win_next;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (cfg.pattern_length > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = cfg.pattern_length;
    end
  end

  assign pat = {cfg.pattern_high, cfg.pattern_low};

  // Append the new byte right after the pending ones.
  assign win_app = (win & ~(WW'(8'hFF) << {cnt, 3'b000}))
                 | (WW'(byte_stream.in_byte) << {cnt, 3'b000});

  assign src_w    = active ? win : win_app;
  assign src_c    = active ? LEN_W'(cnt) : LEN_W'(cnt) + LEN_W'(1);
  assign src_last = active ? flush : byte_stream.stream_end;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      byte_ok[i] = (src_w[i*8 +: 8] == pat[i*8 +: 8]) || (LEN_W'(i) >= len);
    end
  end

  assign full_window = src_c >= len;
  assign hit         = full_window && (&byte_ok);
  assign act         = full_window || (src_last && (src_c != '0));
  assign drop        = hit ? len : LEN_W'(1);
  assign cnt_next    = src_c - drop;
  assign more        = (cnt_next >= len) || (src_last && (cnt_next != '0));
  assign win_next    = src_w >> {drop, 3'b000};

  assign take              = !active && byte_stream.valid && !cmd_full;
  assign byte_stream.ready = !active && !cmd_full;
  assign step              = take || (active && !cmd_full);
  assign cmd_push          = step && act;

  always_comb begin
    cmd.star        = hit;
    cmd.run_len     = len;
    cmd.data        = src_w[7:0];
    cmd.run_last    = !more;
    cmd.stream_done = !more && src_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      flush  <= 1'b0;
    end else if (step) begin
      if (act) begin
        active <= more;
        cnt    <= CW'(cnt_next);
        flush  <= src_last;
      end else begin
        cnt    <= CW'(src_c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      win <= act ? win_next : src_w;
    end
  end

endmodule

`default_nettype wire

/* rtl/smask_cmd_fifo.sv */
// ---------------------------------------------------------------------------
// smask_cmd_fifo
// Short command queue between the decision front and the output back.
// ---------------------------------------------------------------------------
`default_nettype none

module smask_cmd_fifo
  import smask_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign full    = fill == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty   = fill == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/smask_back.sv */
// ---------------------------------------------------------------------------
// smask_back
// Expands queued commands into output bytes, one per cycle while the
// receiver is ready, behind an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module smask_back
  import smask_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        empty,
  output logic        pop,
  smask_out_if.source masked_stream
);

  logic [LEN_W-1:0] sent;

  logic slot_free;
  logic emit;
  logic cmd_done;

  assign slot_free = !masked_stream.valid || masked_stream.ready;
  assign emit      = slot_free && !empty;
  assign cmd_done  = !head.star || ((sent + LEN_W'(1)) == head.run_len);
  assign pop       = emit && cmd_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      masked_stream.valid <= 1'b0;
      sent                <= '0;
    end else begin
      if (slot_free) begin
        masked_stream.valid <= !empty;
      end
      if (emit) begin
        // advance within a star run, restart on the next command
        sent <= cmd_done ? '0 : sent + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      masked_stream.out_byte    <= head.star ? STAR_BYTE : head.data;
      masked_stream.run_last    <= head.run_last && cmd_done;
      masked_stream.stream_done <= head.stream_done && cmd_done;
    end
  end

endmodule

`default_nettype wire

/* rtl/stream_pattern_mask.sv */
// ---------------------------------------------------------------------------
// stream_pattern_mask
// Copies a byte stream and replaces each non-overlapping pattern hit with
// asterisks.
//
// byte_stream carries one text byte per transaction plus stream_end on the
// final byte. masked_stream returns the bytes in order, asterisks in place
// of every greedy left-to-right match of the configured pattern; run_last
// marks the last output of an input byte, stream_done the last output of
// the stream. Pattern length and bytes are written through cfg_write_en,
// cfg_index and cfg_write_data while the block is idle.
// The front takes one byte per cycle unless flushing or the command queue is
// full, and makes one window decision per cycle. With the receiver ready, a
// byte closing a match gives one output per cycle for the whole asterisk
// run, stream_end flushes held bytes at one per cycle, and the sustained
// rate is one byte per cycle, set by the single decision unit. Commands pass
// through the queue, then the output register; a stalled receiver fills the
// output register, then the four-entry queue, then drops byte_stream.ready.
// Reset clears window, queue and output and restores length 1, zero pattern.
// ---------------------------------------------------------------------------
`default_nettype none

module stream_pattern_mask
  import smask_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  smask_in_if.sink              byte_stream,
  smask_out_if.source           masked_stream,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_write_data
);

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic full;
  logic pop;
  logic empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= LEN_W'(1);
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_write_data[LEN_W-1:0];
        REG_PATTERN_LOW:    cfg.pattern_low    <= cfg_write_data;
        REG_PATTERN_HIGH:   cfg.pattern_high   <= cfg_write_data;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  smask_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_stream(byte_stream),
    .cfg        (cfg),
    .cmd_full   (full),
    .cmd_push   (push),
    .cmd        (push_cmd)
  );

  smask_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (full),
    .pop     (pop),
    .head    (head),
    .empty   (empty)
  );

  smask_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .masked_stream(masked_stream)
  );

endmodule

`default_nettype wire
